/* rtl/core/rbmf_pkg.sv */
// ---------------------------------------------------------------------------
// rbmf_pkg
// Shared constants, types and the reciprocal table of the 5x5 RGB box mean
// filter.
// ---------------------------------------------------------------------------
package rbmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int RADIUS     = 2;
  localparam int WIN        = 2 * RADIUS + 1;
  localparam int LINES      = 2 * RADIUS;
  localparam int TAPS       = WIN * WIN;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(LINES);
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int POS_W      = 26;
  localparam int RSUM_W     = 11;
  localparam int SUM_W      = 13;
  localparam int RECIP_K    = 18;
  localparam int RECIP_W    = RECIP_K + 1;
  localparam int PROD_W     = SUM_W + RECIP_W;

  // register indexes of the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef logic [TAPS-1:0][7:0] chan_win_t;

  // stage enables of one color lane
  typedef struct packed {
    logic en_row;
    logic en_add;
    logic en_mul;
  } lane_ctl_t;

  // ceil(2^18 / cnt) for every count a clipped window can have
  function automatic logic [RECIP_W-1:0] recip(input logic [4:0] cnt);
    logic [RECIP_W-1:0] m;
    m = '0;
    case (cnt)
      5'd1:    m = 19'd262144;
      5'd2:    m = 19'd131072;
      5'd3:    m = 19'd87382;
      5'd4:    m = 19'd65536;
      5'd5:    m = 19'd52429;
      5'd6:    m = 19'd43691;
      5'd8:    m = 19'd32768;
      5'd9:    m = 19'd29128;
      5'd10:   m = 19'd26215;
      5'd12:   m = 19'd21846;
      5'd15:   m = 19'd17477;
      5'd16:   m = 19'd16384;
      5'd20:   m = 19'd13108;
      5'd25:   m = 19'd10486;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/rbmf_if.sv */
// ---------------------------------------------------------------------------
// rbmf_in_if / rbmf_out_if
// Valid/ready channels for pixel input and filtered result output.
// ---------------------------------------------------------------------------
interface rbmf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface rbmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_smooth;
  logic [7:0] green_smooth;
  logic [7:0] blue_smooth;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, red_smooth, green_smooth, blue_smooth, row_end, frame_end,
                  input ready);
  modport sink   (input valid, red_smooth, green_smooth, blue_smooth, row_end, frame_end,
                  output ready);
endinterface

/* rtl/core/rbmf_line_store.sv */
// ---------------------------------------------------------------------------
// rbmf_line_store
// Four row memories of RGB pixels; one column read from all rows, one written.
// ---------------------------------------------------------------------------
module rbmf_line_store (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [rbmf_pkg::COL_W-1:0]            addr,
  input  logic [rbmf_pkg::SLOT_W-1:0]           wslot,
  input  rbmf_pkg::pix_t                        wdata,
  output rbmf_pkg::pix_t [rbmf_pkg::LINES-1:0]  rdata
);

  for (genvar s = 0; s < rbmf_pkg::LINES; s++) begin : g_row
    rbmf_pkg::pix_t mem [rbmf_pkg::MAX_WIDTH];
    rbmf_pkg::pix_t rd_r;

    // read old contents, then write the slot of the current row
    always_ff @(posedge clk) begin
      if (en) begin
        rd_r <= mem[addr];
        if (wslot == rbmf_pkg::SLOT_W'(s)) begin
          mem[addr] <= wdata;
        end
      end
    end

    assign rdata[s] = rd_r;
  end

endmodule

/* rtl/core/rbmf_lane.sv */
// ---------------------------------------------------------------------------
// rbmf_lane
// One color lane: masked window sum in two stages, then reciprocal multiply.
// ---------------------------------------------------------------------------
module rbmf_lane (
  input  logic                          clk,
  input  rbmf_pkg::lane_ctl_t           ctl,
  input  rbmf_pkg::chan_win_t           win,
  input  logic [rbmf_pkg::TAPS-1:0]     mask,
  input  logic [rbmf_pkg::RECIP_W-1:0]  recip,
  output logic [7:0]                    mean
);

  logic [rbmf_pkg::WIN-1:0][rbmf_pkg::RSUM_W-1:0] row_r, row_nxt;
  logic [rbmf_pkg::SUM_W-1:0]                     sum_r, sum_nxt;
  logic [rbmf_pkg::PROD_W-1:0]                    prod_r;

  // sum each window row over its valid taps
  always_comb begin
    for (int i = 0; i < rbmf_pkg::WIN; i++) begin
      row_nxt[i] = '0;
      for (int d = 0; d < rbmf_pkg::WIN; d++) begin
        if (mask[i*rbmf_pkg::WIN+d]) begin
          row_nxt[i] = row_nxt[i] + rbmf_pkg::RSUM_W'(win[i*rbmf_pkg::WIN+d]);
        end
      end
    end
  end

  // add the row sums
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < rbmf_pkg::WIN; i++) begin
      sum_nxt = sum_nxt + rbmf_pkg::SUM_W'(row_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_row) row_r <= row_nxt;
    if (ctl.en_add) sum_r <= sum_nxt;
    if (ctl.en_mul) prod_r <= rbmf_pkg::PROD_W'(sum_r) * rbmf_pkg::PROD_W'(recip);
  end

  assign mean = prod_r[rbmf_pkg::RECIP_K +: 8];

endmodule

/* rtl/core/rgb_box_mean_filter_5x5.sv */
// ---------------------------------------------------------------------------
// rgb_box_mean_filter_5x5
// Raster-order RGB 5x5 box mean with border clipping, three color lanes.
// ---------------------------------------------------------------------------
//  channel  | direction | transaction
//  in_if    | sink      | one pixel or one flush tick
//  out_if   | source    | one filtered pixel with row and frame end flags
//  cfg_*    | write     | image width (index 0), image height (index 1)
//
//  A pixel without result passes accept and line store read; a pixel or
//  flush tick with a result passes accept, read, row sums, total, multiply
//  and output load, which waits while a held result is not taken. An
//  ignored flush tick is only accepted. Input waits for the idle sequencer.
//  Output register lets the next transaction enter while a result waits.
//  Reset (rst_n, synchronous) clears counters, window and control; no pass.
// ---------------------------------------------------------------------------
module rgb_box_mean_filter_5x5 (
  input  logic               clk,
  input  logic               rst_n,
  rbmf_in_if.sink            in_if,
  rbmf_out_if.source         out_if,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [12:0]        cfg_wdata
);

  localparam int COL_W = rbmf_pkg::COL_W;
  localparam int WIN   = rbmf_pkg::WIN;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [rbmf_pkg::WREG_W-1:0] width_r;
  logic [rbmf_pkg::HREG_W-1:0] height_r;
  logic [rbmf_pkg::WREG_W-1:0] w_eff;
  logic [rbmf_pkg::HREG_W-1:0] h_eff;

  logic [COL_W-1:0]              ic_r, ic_nxt, oc_r, oc_nxt;
  logic [rbmf_pkg::HREG_W-1:0]   ir_r, ir_nxt;
  logic [rbmf_pkg::HREG_W-2:0]   or_r, or_nxt;

  logic [COL_W-1:0]              cur_ic, cur_oc;
  logic [rbmf_pkg::HREG_W-1:0]   cur_ir;
  logic [rbmf_pkg::HREG_W-2:0]   cur_or;
  logic [rbmf_pkg::POS_W-1:0]    lin_pos, lag;
  logic [rbmf_pkg::WREG_W-1:0]   ic_inc, oc_inc;
  logic [rbmf_pkg::HREG_W-1:0]   or_inc, or_adv;

  logic accept, draining, go, restart_in, emit, row_end, frame_end, wrap_i;
  rbmf_pkg::pix_t pix;

  // job held through the sequencer
  rbmf_pkg::pix_t              pix_r;
  logic [rbmf_pkg::SLOT_W-1:0] slot_r;
  logic                        emit_r, row_end_r, frame_end_r;
  logic [rbmf_pkg::HREG_W-2:0] orow_r;
  logic [COL_W-1:0]            ocol_r;

  rbmf_pkg::pix_t [rbmf_pkg::LINES-1:0] ls_rdata;
  rbmf_pkg::pix_t [WIN-1:0][WIN-1:0]    win_r;
  rbmf_pkg::pix_t [WIN-1:0]             col;

  logic [WIN-1:0]                row_v, col_v;
  logic [rbmf_pkg::TAPS-1:0]     mask;
  logic [2:0]                    rc, cc;
  logic [4:0]                    cnt;
  logic [rbmf_pkg::RECIP_W-1:0]  recip_r;
  rbmf_pkg::chan_win_t           win_red, win_green, win_blue;
  rbmf_pkg::lane_ctl_t           lane_ctl;
  logic [7:0]                    mean_red, mean_green, mean_blue;

  logic       out_valid_r, out_load;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_row_end_r, out_frame_end_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rbmf_pkg::WREG_W'(640);
      height_r <= rbmf_pkg::HREG_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rbmf_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[rbmf_pkg::WREG_W-1:0];
        rbmf_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        default:              width_r  <= width_r;
      endcase
    end
  end

  // saturate the sizes
  always_comb begin
    if (width_r == '0) w_eff = rbmf_pkg::WREG_W'(1);
    else if (width_r > rbmf_pkg::WREG_W'(rbmf_pkg::MAX_WIDTH))
      w_eff = rbmf_pkg::WREG_W'(rbmf_pkg::MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = rbmf_pkg::HREG_W'(1);
    else if (height_r > rbmf_pkg::HREG_W'(rbmf_pkg::MAX_HEIGHT))
      h_eff = rbmf_pkg::HREG_W'(rbmf_pkg::MAX_HEIGHT);
    else h_eff = height_r;
  end

  // ---------------- position counters ----------------
  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign draining    = (ir_r >= h_eff);
  assign go          = accept && (!in_if.action || draining);
  assign restart_in  = !in_if.action && draining;
  assign pix         = in_if.action ? '0 : rbmf_pkg::pix_t'({in_if.red_in, in_if.green_in,
                                                           in_if.blue_in});

  always_comb begin
    cur_ic  = restart_in ? '0 : ic_r;
    cur_ir  = restart_in ? '0 : ir_r;
    cur_oc  = restart_in ? '0 : oc_r;
    cur_or  = restart_in ? '0 : or_r;

    // linear input position at the current width against the output lag
    lin_pos = rbmf_pkg::POS_W'(cur_ir) * rbmf_pkg::POS_W'(w_eff) + rbmf_pkg::POS_W'(cur_ic);
    lag     = (rbmf_pkg::POS_W'(w_eff) << 1) + rbmf_pkg::POS_W'(rbmf_pkg::RADIUS);
    emit    = (lin_pos >= lag) && ({1'b0, cur_or} < h_eff);

    ic_inc = rbmf_pkg::WREG_W'(cur_ic) + 1'b1;
    wrap_i = (ic_inc >= w_eff);
    ic_nxt = wrap_i ? '0 : ic_inc[COL_W-1:0];
    ir_nxt = wrap_i ? cur_ir + 1'b1 : cur_ir;

    oc_inc    = rbmf_pkg::WREG_W'(cur_oc) + 1'b1;
    row_end   = (oc_inc >= w_eff);
    or_inc    = {1'b0, cur_or} + 1'b1;
    frame_end = row_end && (or_inc >= h_eff);
    oc_nxt    = cur_oc;
    or_adv    = {1'b0, cur_or};
    if (emit) begin
      oc_nxt = row_end ? '0 : oc_inc[COL_W-1:0];
      or_adv = row_end ? or_inc : {1'b0, cur_or};
    end
    or_nxt = or_adv[rbmf_pkg::HREG_W-2:0];

    // frame complete: all positions return to zero
    if (or_adv >= h_eff) begin
      ic_nxt  = '0;
      ir_nxt  = '0;
      oc_nxt  = '0;
      or_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r  <= '0;
      ir_r  <= '0;
      oc_r  <= '0;
      or_r  <= '0;
    end else if (go) begin
      ic_r  <= ic_nxt;
      ir_r  <= ir_nxt;
      oc_r  <= oc_nxt;
      or_r  <= or_nxt;
    end
  end

  // capture the job
  always_ff @(posedge clk) begin
    if (go) begin
      pix_r       <= pix;
      slot_r      <= cur_ir[rbmf_pkg::SLOT_W-1:0];
      orow_r      <= cur_or;
      ocol_r      <= cur_oc;
      row_end_r   <= row_end;
      frame_end_r <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) emit_r <= 1'b0;
    else if (go) emit_r <= emit;
  end

  // ---------------- line store ----------------
  rbmf_line_store u_line_store (
    .clk   (clk),
    .en    (go),
    .addr  (cur_ic),
    .wslot (cur_ir[rbmf_pkg::SLOT_W-1:0]),
    .wdata (pix),
    .rdata (ls_rdata)
  );

  // ---------------- window ----------------
  always_comb begin
    for (int i = 0; i < rbmf_pkg::LINES; i++) begin
      col[i] = ls_rdata[slot_r + rbmf_pkg::SLOT_W'(i)];
    end
    col[WIN-1] = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (state_r == S_LOAD) begin
      for (int i = 0; i < WIN; i++) begin
        for (int d = 0; d < WIN - 1; d++) begin
          win_r[i][d] <= win_r[i][d+1];
        end
        win_r[i][WIN-1] <= col[i];
      end
    end
  end

  // ---------------- border mask and count ----------------
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_v[i] = (14'(orow_r) + 14'(i) >= 14'(rbmf_pkg::RADIUS)) &&
                 (14'(orow_r) + 14'(i) < 14'(h_eff) + 14'(rbmf_pkg::RADIUS));
      col_v[i] = (13'(ocol_r) + 13'(i) >= 13'(rbmf_pkg::RADIUS)) &&
                 (13'(ocol_r) + 13'(i) < 13'(w_eff) + 13'(rbmf_pkg::RADIUS));
    end
    for (int i = 0; i < WIN; i++) begin
      for (int d = 0; d < WIN; d++) begin
        mask[i*WIN+d] = row_v[i] && col_v[d];
        win_red[i*WIN+d]   = win_r[i][d].r;
        win_green[i*WIN+d] = win_r[i][d].g;
        win_blue[i*WIN+d]  = win_r[i][d].b;
      end
    end
    rc  = 3'($countones(row_v));
    cc  = 3'($countones(col_v));
    cnt = {2'b00, rc} * {2'b00, cc};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ROW) recip_r <= rbmf_pkg::recip(cnt);
  end

  // ---------------- color lanes ----------------
  assign lane_ctl.en_row = (state_r == S_ROW);
  assign lane_ctl.en_add = (state_r == S_ADD);
  assign lane_ctl.en_mul = (state_r == S_MUL);

  rbmf_lane u_lane_red (
    .clk (clk), .ctl (lane_ctl), .win (win_red), .mask (mask), .recip (recip_r),
    .mean (mean_red)
  );

  rbmf_lane u_lane_green (
    .clk (clk), .ctl (lane_ctl), .win (win_green), .mask (mask), .recip (recip_r),
    .mean (mean_green)
  );

  rbmf_lane u_lane_blue (
    .clk (clk), .ctl (lane_ctl), .win (win_blue), .mask (mask), .recip (recip_r),
    .mean (mean_blue)
  );

  // ---------------- sequencer ----------------
  assign out_load = (state_r == S_PUSH) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (go) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = emit_r ? S_ROW : S_IDLE;
      S_ROW:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PUSH;
      S_PUSH:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- merge into output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r       <= mean_red;
      out_green_r     <= mean_green;
      out_blue_r      <= mean_blue;
      out_row_end_r   <= row_end_r;
      out_frame_end_r <= frame_end_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.red_smooth   = out_red_r;
  assign out_if.green_smooth = out_green_r;
  assign out_if.blue_smooth  = out_blue_r;
  assign out_if.row_end      = out_row_end_r;
  assign out_if.frame_end    = out_frame_end_r;

`ifndef SYNTH
  a_mul_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_PUSH))
    else $error("multiply stage did not hand off to output stage");

  a_pixel_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_if.action) |=> (state_r == S_LOAD))
    else $error("accepted pixel did not enter the window load");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && !out_valid_r) |=> out_valid_r)
    else $error("result not loaded into an empty output register");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && !emit_r) |=> (state_r == S_IDLE))
    else $error("position without result entered the lanes");
`endif

endmodule
